### rtl/prs_pkg.sv
package prs_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int SCORE_FRAC_BITS_DEF = 16;
    localparam int SCORE_W = 32;
    localparam int RANK_W = 6;
    localparam int RATIO_W = 17;
    localparam int FRAC_W = 16;

    typedef enum logic [3:0] {
        S_LOAD,
        S_GAP,
        S_JREAD,
        S_IREAD,
        S_ICMP,
        S_PLACE,
        S_SREAD,
        S_SWAIT,
        S_DIV,
        S_EMIT,
        S_DONE
    } t_state;

    // Request to the divider and its reply
    typedef struct packed {
        logic             start;
        logic [6:0]       num;
        logic [6:0]       den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [RATIO_W-1:0]   quo;
    } t_div_rsp;

endpackage

### rtl/prs_store.sv
module prs_store #(
    parameter int MAX_ITEMS = prs_pkg::MAX_ITEMS_DEF,
    parameter int AW = $clog2(MAX_ITEMS)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [prs_pkg::SCORE_W:0]   i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [prs_pkg::SCORE_W:0]   o_rdata
);

    // score in the upper bits, label in bit 0
    logic [prs_pkg::SCORE_W:0] r_mem [MAX_ITEMS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/prs_div.sv
module prs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prs_pkg::t_div_req i_req,
    output prs_pkg::t_div_rsp o_rsp
);

    localparam int QW = prs_pkg::RATIO_W;
    localparam int NW = 7 + prs_pkg::FRAC_W;

    logic [NW-1:0] r_num;
    logic [7:0]    r_rem;
    logic [6:0]    r_den;
    logic [QW-1:0] r_quo;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [7:0]    w_trial;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem[6:0], r_num[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= {i_req.num, {prs_pkg::FRAC_W{1'b0}}};
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= 5'(NW);
                r_busy <= (i_req.den != 7'd0);
                r_done <= (i_req.den == 7'd0);
            end else if (r_busy) begin
                r_num <= {r_num[NW-2:0], 1'b0};
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### rtl/precision_recall_sweep_core.sv
// Collects up to MAX_ITEMS scored items, one per cycle while o_stall is low,
// in a memory with one read port and one write port. An item with last_item
// set starts an in-place Shell sort that walks the memory with one read and
// one write per cycle. The sweep then reads each rank and runs two serial
// divisions (the recall division ends without iterating when the set has no
// positives), and then offers the result until it is taken. o_stall
// stays high from the last item until the sweep has ended and the final result,
// if any, has been taken.
module precision_recall_sweep_core #(
    parameter int MAX_ITEMS = prs_pkg::MAX_ITEMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [prs_pkg::SCORE_W-1:0] i_score,
    input  logic                               i_is_positive,
    input  logic                               i_last_item,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [prs_pkg::RANK_W-1:0]         o_rank,
    output logic [prs_pkg::RATIO_W-1:0]        o_recall,
    output logic [prs_pkg::RATIO_W-1:0]        o_precision,
    output logic                               o_dropped_items,
    output logic                               o_final_result
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = 7;
    localparam int SW = prs_pkg::SCORE_W;
    localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

    prs_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, r_pos, r_gap, r_j, r_i, r_seen;
    logic          r_ovf, r_second;
    logic [SW:0]   r_key;
    logic [prs_pkg::RATIO_W-1:0] r_rec, r_prec;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [SW:0]   w_wdata, w_rdata;
    prs_pkg::t_div_req w_req;
    prs_pkg::t_div_rsp w_rsp;
    logic          w_in_acc, w_gt;

    prs_store #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    prs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign o_stall  = (r_state != prs_pkg::S_LOAD);
    assign w_in_acc = i_valid && !o_stall;
    assign w_gt     = $signed(w_rdata[SW:1]) > $signed(r_key[SW:1]);

    logic [CW-1:0] w_above, w_rden;
    assign w_above = r_pos - r_seen - CW'(w_rdata[0]);
    assign w_rden  = r_count - r_j - CW'(1);

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = {i_score, i_is_positive};
        w_raddr = r_j[AW-1:0];
        w_req   = '0;
        unique case (r_state)
            prs_pkg::S_LOAD: begin
                w_we = w_in_acc && (r_count < CAP);
                if (w_in_acc && i_last_item) n_state = prs_pkg::S_GAP;
            end
            prs_pkg::S_GAP: begin
                if (r_gap == '0) n_state = prs_pkg::S_SREAD;
                else if (r_j >= r_count) n_state = prs_pkg::S_GAP;
                else n_state = prs_pkg::S_JREAD;
            end
            prs_pkg::S_JREAD: begin
                w_raddr = r_j[AW-1:0];
                n_state = prs_pkg::S_IREAD;
            end
            prs_pkg::S_IREAD: begin
                w_raddr = r_i[AW-1:0];
                n_state = prs_pkg::S_ICMP;
            end
            prs_pkg::S_ICMP: begin
                if (w_gt) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_i + r_gap);
                    w_wdata = w_rdata;
                    if (r_i >= r_gap) begin
                        w_raddr = AW'(r_i - r_gap);
                        n_state = prs_pkg::S_ICMP;
                    end else begin
                        n_state = prs_pkg::S_PLACE;
                    end
                end else begin
                    n_state = prs_pkg::S_PLACE;
                end
            end
            prs_pkg::S_PLACE: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_i);
                w_wdata = r_key;
                n_state = prs_pkg::S_GAP;
            end
            prs_pkg::S_SREAD: begin
                w_raddr = r_j[AW-1:0];
                if (r_j + CW'(1) >= r_count) n_state = prs_pkg::S_DONE;
                else n_state = prs_pkg::S_SWAIT;
            end
            prs_pkg::S_SWAIT: begin
                if (r_j == '0) begin
                    n_state = prs_pkg::S_SREAD;
                end else begin
                    w_req.start = 1'b1;
                    w_req.num   = w_above;
                    w_req.den   = r_pos;
                    n_state     = prs_pkg::S_DIV;
                end
            end
            prs_pkg::S_DIV: begin
                if (w_rsp.done) begin
                    if (!r_second) begin
                        w_req.start = 1'b1;
                        w_req.num   = r_key[CW-1:0];
                        w_req.den   = w_rden;
                    end else begin
                        n_state = prs_pkg::S_EMIT;
                    end
                end
            end
            prs_pkg::S_EMIT: begin
                if (!i_stall) begin
                    if (r_j + CW'(2) >= r_count) n_state = prs_pkg::S_DONE;
                    else n_state = prs_pkg::S_SREAD;
                end
            end
            prs_pkg::S_DONE: n_state = prs_pkg::S_LOAD;
            default: n_state = prs_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prs_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pos    <= '0;
            r_ovf    <= 1'b0;
            r_second <= 1'b0;
        end else begin
            case (r_state)
                prs_pkg::S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count < CAP) begin
                            r_count <= r_count + CW'(1);
                            r_pos   <= r_pos + CW'(i_is_positive);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_item) begin
                            r_gap <= (r_count < CAP) ? ((r_count + CW'(1)) >> 1)
                                                     : (r_count >> 1);
                            r_j   <= (r_count < CAP) ? ((r_count + CW'(1)) >> 1)
                                                     : (r_count >> 1);
                        end
                    end
                end
                prs_pkg::S_GAP: begin
                    if (r_gap != '0 && r_j >= r_count) begin
                        r_gap <= r_gap >> 1;
                        r_j   <= r_gap >> 1;
                    end
                    if (r_gap == '0) begin
                        r_j    <= '0;
                        r_seen <= '0;
                    end
                end
                prs_pkg::S_JREAD: r_i <= r_j - r_gap;
                prs_pkg::S_IREAD: r_key <= w_rdata;
                prs_pkg::S_ICMP: begin
                    if (w_gt && r_i >= r_gap) r_i <= r_i - r_gap;
                    else if (!w_gt) r_i <= r_i + r_gap;
                end
                prs_pkg::S_PLACE: r_j <= r_j + CW'(1);
                prs_pkg::S_SWAIT: begin
                    r_seen <= r_seen + CW'(w_rdata[0]);
                    r_key  <= {{(SW+1-CW){1'b0}}, w_above};
                    r_second <= 1'b0;
                    if (r_j == '0) r_j <= r_j + CW'(1);
                end
                prs_pkg::S_DIV: begin
                    if (w_rsp.done && !r_second) begin
                        r_rec    <= w_rsp.quo;
                        r_second <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_prec <= w_rsp.quo;
                    end
                end
                prs_pkg::S_EMIT: if (!i_stall) r_j <= r_j + CW'(1);
                prs_pkg::S_DONE: begin
                    r_count <= '0;
                    r_pos   <= '0;
                    r_ovf   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // in ICMP with no move, r_i is the hole minus gap; PLACE writes at r_i
    // (fixed up above); when the chain runs off the bottom the hole is r_i
    always_comb begin
        o_valid         = (r_state == prs_pkg::S_EMIT);
        o_rank          = r_j[prs_pkg::RANK_W-1:0];
        o_recall        = r_rec;
        o_precision     = r_prec;
        o_dropped_items = r_ovf;
        o_final_result  = (r_j + CW'(2) == r_count);
    end

endmodule
